// ----- src/gle_pkg.sv -----
// Shared constants, command/status types and helper functions of the GIF LZW encoder.
package gle_pkg;

    localparam int HASH_SIZE_DEF  = 5003;
    localparam int MAX_BITS_DEF   = 12;
    localparam int CODE_W_MAX     = 12;
    localparam int PIX_W          = 8;
    localparam int SIZE_W         = 4;
    localparam int WIDTH_W        = 4;
    localparam int MIN_SIZE_LO    = 2;
    localparam int MIN_SIZE_HI    = 8;
    localparam int MIN_SIZE_RST   = 8;
    localparam int BYTE_W         = 8;

    // APB register map
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;
    localparam logic REG_MIN_CODE_SIZE = 1'b0;

    // Command to the bit packer
    typedef struct packed {
        logic                  send;
        logic                  end_item;
        logic                  last;
        logic [CODE_W_MAX-1:0] code;
        logic [WIDTH_W-1:0]    width;
    } pk_cmd_t;

    // Command to the hash table unit
    typedef struct packed {
        logic                  start;
        logic                  insert;
        logic                  clear;
        logic [PIX_W-1:0]      pixel;
        logic [CODE_W_MAX-1:0] prefix;
        logic [CODE_W_MAX-1:0] code;
    } ht_cmd_t;

    // Status of the hash table unit
    typedef struct packed {
        logic                  busy;
        logic                  hit;
        logic                  slot;
        logic [CODE_W_MAX-1:0] code;
    } ht_stat_t;

    // Left shift of the pixel in the first hash index (elaboration only)
    function automatic int hash_shift(input int hs);
        int f;
        int s;
        f = hs;
        s = 0;
        while (f < 65536) begin
            f = f * 2;
            s = s + 1;
        end
        return (s > 8) ? 0 : 8 - s;
    endfunction

    // Highest code before the width grows
    function automatic logic [CODE_W_MAX:0] limit_for(input logic [WIDTH_W-1:0] w,
                                                      input int max_bits);
        logic [CODE_W_MAX:0] one;
        one = (CODE_W_MAX+1)'(1);
        if (int'(w) >= max_bits)
            return one << max_bits;
        return (one << w) - one;
    endfunction

endpackage

// ----- src/gle_intf.sv -----
// Request channel interfaces: pixels in, packed code bytes out.
interface gle_pix_if;
    logic                       valid;
    logic                       ready;
    logic [gle_pkg::PIX_W-1:0]  pixel;
    logic                       last_pixel;

    modport source (output valid, pixel, last_pixel, input ready);
    modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

interface gle_byte_if;
    logic                       valid;
    logic                       ready;
    logic [gle_pkg::BYTE_W-1:0] out_byte;
    logic                       run_end;
    logic                       stream_end;

    modport source (output valid, out_byte, run_end, stream_end, input ready);
    modport sink   (input valid, out_byte, run_end, stream_end, output ready);
endinterface

// ----- src/gle_hash_table.sv -----
// Double-hashed dictionary memory with a one-probe-per-cycle probe unit and clearing sweep.
module gle_hash_table #(
    parameter int HASH_SIZE     = gle_pkg::HASH_SIZE_DEF,
    parameter int MAX_CODE_BITS = gle_pkg::MAX_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gle_pkg::ht_cmd_t  cmd,
    output gle_pkg::ht_stat_t stat
);

    localparam int IDX_W  = $clog2(HASH_SIZE);
    localparam int SHIFT  = gle_pkg::hash_shift(HASH_SIZE);
    localparam int KEY_W  = gle_pkg::PIX_W + MAX_CODE_BITS;
    localparam int DATA_W = 1 + KEY_W + MAX_CODE_BITS;
    localparam int RAW_W  = (gle_pkg::PIX_W + SHIFT > MAX_CODE_BITS) ?
                            gle_pkg::PIX_W + SHIFT : MAX_CODE_BITS;
    localparam int CMP_W  = ((RAW_W > IDX_W) ? RAW_W : IDX_W) + 1;
    localparam logic [CMP_W-1:0] HS_C   = CMP_W'(HASH_SIZE);
    localparam logic [IDX_W-1:0] HS_I   = IDX_W'(HASH_SIZE);
    localparam logic [IDX_W-1:0] LAST_I = IDX_W'(HASH_SIZE - 1);

    localparam logic [1:0] H_IDLE  = 2'd0;
    localparam logic [1:0] H_PROBE = 2'd1;
    localparam logic [1:0] H_CLEAR = 2'd2;

    logic [DATA_W-1:0] mem [HASH_SIZE];

    logic [1:0]                state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          disp_reg, disp_next;
    logic [KEY_W-1:0]          key_reg, key_next;
    logic [IDX_W-1:0]          n_reg, n_next;
    logic [IDX_W-1:0]          clr_reg, clr_next;
    logic                      hit_reg, hit_next;
    logic                      slot_reg, slot_next;
    logic [MAX_CODE_BITS-1:0]  code_reg, code_next;
    logic [DATA_W-1:0]         rd_data_reg;

    logic [CMP_W-1:0]          raw, sub1;
    logic [IDX_W-1:0]          idx0, disp0, idx_step, rd_addr, waddr;
    logic [IDX_W:0]            wrap_sum;
    logic                      rd_valid;
    logic [KEY_W-1:0]          rd_key;
    logic [MAX_CODE_BITS-1:0]  rd_code;
    logic                      we;
    logic [DATA_W-1:0]         wdata;

    // First index and displacement
    always_comb
    begin
        raw   = (CMP_W'(cmd.pixel) << SHIFT) ^ CMP_W'(cmd.prefix[MAX_CODE_BITS-1:0]);
        sub1  = (raw >= HS_C) ? raw - HS_C : raw;
        idx0  = (sub1 >= HS_C) ? '0 : sub1[IDX_W-1:0];
        disp0 = (idx0 == '0) ? IDX_W'(1) : HS_I - idx0;
    end

    // Next probe position
    always_comb
    begin
        wrap_sum = {1'b0, idx_reg} + {1'b0, HS_I - disp_reg};
        idx_step = (idx_reg >= disp_reg) ? idx_reg - disp_reg : wrap_sum[IDX_W-1:0];
    end

    assign rd_valid = rd_data_reg[DATA_W-1];
    assign rd_key   = rd_data_reg[DATA_W-2 -: KEY_W];
    assign rd_code  = rd_data_reg[MAX_CODE_BITS-1:0];
    assign rd_addr  = (state_reg == H_PROBE) ? idx_step : idx0;

    // Write port: insertion or clearing sweep
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = {1'b1, key_reg, cmd.code[MAX_CODE_BITS-1:0]};
        if (state_reg == H_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (state_reg == H_IDLE && cmd.insert)
        begin
            we = 1'b1;
        end
    end

    // Dictionary memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Probe sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        disp_next  = disp_reg;
        key_next   = key_reg;
        n_next     = n_reg;
        clr_next   = clr_reg;
        hit_next   = hit_reg;
        slot_next  = slot_reg;
        code_next  = code_reg;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.clear)
                begin
                    clr_next   = '0;
                    state_next = H_CLEAR;
                end
                else if (cmd.start)
                begin
                    idx_next   = idx0;
                    disp_next  = disp0;
                    key_next   = {cmd.pixel, cmd.prefix[MAX_CODE_BITS-1:0]};
                    n_next     = '0;
                    state_next = H_PROBE;
                end
            end
            H_PROBE:
            begin
                if (!rd_valid)
                begin
                    hit_next   = 1'b0;
                    slot_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else if (rd_key == key_reg)
                begin
                    hit_next   = 1'b1;
                    code_next  = rd_code;
                    state_next = H_IDLE;
                end
                else if (n_reg == LAST_I)
                begin
                    // every slot probed: miss without a free slot
                    hit_next   = 1'b0;
                    slot_next  = 1'b0;
                    state_next = H_IDLE;
                end
                else
                begin
                    n_next   = n_reg + IDX_W'(1);
                    idx_next = idx_step;
                end
            end
            H_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == LAST_I)
                begin
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            hit_reg   <= 1'b0;
            slot_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        disp_reg <= disp_next;
        key_reg  <= key_next;
        n_reg    <= n_next;
        clr_reg  <= clr_next;
        code_reg <= code_next;
    end

    assign stat.busy = (state_reg != H_IDLE);
    assign stat.hit  = hit_reg;
    assign stat.slot = slot_reg;
    assign stat.code = gle_pkg::CODE_W_MAX'(code_reg);

endmodule

// ----- src/gle_bit_packer.sv -----
// Bit packer: gathers variable-width codes LSB first and sends bytes, marking item and stream ends.
module gle_bit_packer #(
    parameter int MAX_CODE_BITS = gle_pkg::MAX_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  gle_pkg::pk_cmd_t cmd,
    output logic             idle,
    gle_byte_if.source       obyte
);

    localparam int ACC_W = MAX_CODE_BITS + 7;
    localparam int CNT_W = $clog2(MAX_CODE_BITS + 8);
    localparam logic [CNT_W-1:0] EIGHT = CNT_W'(8);

    localparam logic [1:0] P_IDLE  = 2'd0;
    localparam logic [1:0] P_DRAIN = 2'd1;
    localparam logic [1:0] P_FLUSH = 2'd2;
    localparam logic [1:0] P_FIN   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              last_reg, last_next;
    logic              st_v_reg, st_v_next;
    logic [7:0]        st_byte_reg, st_byte_next;
    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg, ob_next;
    logic              re_reg, re_next;
    logic              se_reg, se_next;

    logic                       out_free, can_step, do_step;
    logic [gle_pkg::CODE_W_MAX:0] cmask;
    logic [gle_pkg::CODE_W_MAX:0] masked;

    assign out_free = !ov_reg || obyte.ready;
    assign can_step = !st_v_reg || out_free;
    assign cmask    = ((gle_pkg::CODE_W_MAX+1)'(1) << cmd.width) - (gle_pkg::CODE_W_MAX+1)'(1);
    assign masked   = {1'b0, cmd.code} & cmask;

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        st_v_next    = st_v_reg;
        st_byte_next = st_byte_reg;
        ov_next      = ov_reg;
        ob_next      = ob_reg;
        re_next      = re_reg;
        se_next      = se_reg;
        do_step      = 1'b0;

        // output register drains when taken
        if (ov_reg && obyte.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            P_IDLE:
            begin
                if (cmd.send)
                begin
                    acc_next   = acc_reg | (ACC_W'(masked) << cnt_reg);
                    cnt_next   = cnt_reg + CNT_W'(cmd.width);
                    state_next = P_DRAIN;
                end
                else if (cmd.end_item)
                begin
                    last_next  = cmd.last;
                    state_next = cmd.last ? P_FLUSH : P_FIN;
                end
            end
            P_DRAIN:
            begin
                if (cnt_reg < EIGHT)
                begin
                    state_next = P_IDLE;
                end
                else if (can_step)
                begin
                    do_step = 1'b1;
                end
            end
            P_FLUSH:
            begin
                if (cnt_reg == '0)
                begin
                    acc_next   = '0;
                    state_next = P_FIN;
                end
                else if (can_step)
                begin
                    do_step = 1'b1;
                end
            end
            P_FIN:
            begin
                if (!st_v_reg)
                begin
                    state_next = P_IDLE;
                end
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    ob_next    = st_byte_reg;
                    re_next    = 1'b1;
                    se_next    = last_reg;
                    st_v_next  = 1'b0;
                    state_next = P_IDLE;
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase

        // one byte out of the accumulator into the staging slot
        if (do_step)
        begin
            if (st_v_reg)
            begin
                ov_next = 1'b1;
                ob_next = st_byte_reg;
                re_next = 1'b0;
                se_next = 1'b0;
            end
            st_v_next    = 1'b1;
            st_byte_next = acc_reg[7:0];
            acc_next     = acc_reg >> 8;
            cnt_next     = (cnt_reg > EIGHT) ? cnt_reg - EIGHT : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            st_v_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            st_v_reg  <= st_v_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        st_byte_reg <= st_byte_next;
        ob_reg      <= ob_next;
        re_reg      <= re_next;
        se_reg      <= se_next;
    end

    assign idle             = (state_reg == P_IDLE);
    assign obyte.valid      = ov_reg;
    assign obyte.out_byte   = ob_reg;
    assign obyte.run_end    = re_reg;
    assign obyte.stream_end = se_reg;

endmodule

// ----- src/gif_lzw_encoder.sv -----
// GIF LZW encoder top level: APB register, per-pixel sequencer, hash unit and bit packer.
//
// One pixel is taken per request; pix.ready is high only while the encoder is idle. A pixel
// that extends the current string passes through accept, start of the probe, memory read
// and compare, result, tail, hand-off to the packer and a wait while the packer closes the
// request; each extra hash collision adds one more probe, as the dictionary memory has a
// single read port. Each code sent and each completed byte also passes through the packer,
// and a stalled output adds its stall. The first pixel of an image and every dictionary-full
// event run a clearing pass over all HASH_SIZE entries (5003 by default) of the dictionary
// memory, one entry a cycle, before the clear code goes out. Bytes leave LSB first
// through a registered output; run_end marks the last byte a pixel caused and stream_end the
// final byte of the image. min_code_size (address 0) is clamped to 2..8 and takes effect at
// the next image start.
module gif_lzw_encoder #(
    parameter int HASH_SIZE     = gle_pkg::HASH_SIZE_DEF,
    parameter int MAX_CODE_BITS = gle_pkg::MAX_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gle_pkg::APB_AW-1:0]   paddr,
    input  logic [gle_pkg::APB_DW-1:0]   pwdata,
    output logic [gle_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    gle_pix_if.sink                      pix,
    gle_byte_if.source                   obyte
);

    localparam int NF_W = MAX_CODE_BITS + 1;
    localparam int SZ_W = gle_pkg::SIZE_W;
    localparam int WD_W = gle_pkg::WIDTH_W;
    localparam logic [NF_W-1:0] FULL_CODE = NF_W'(1) << MAX_CODE_BITS;
    localparam logic [WD_W-1:0] MAX_W     = WD_W'(MAX_CODE_BITS);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_START      = 4'd1;
    localparam logic [3:0] S_CLR_WAIT   = 4'd2;
    localparam logic [3:0] S_SEND_CLR   = 4'd3;
    localparam logic [3:0] S_PROBE      = 4'd4;
    localparam logic [3:0] S_PROBE_WAIT = 4'd5;
    localparam logic [3:0] S_MISS       = 4'd6;
    localparam logic [3:0] S_TAIL       = 4'd7;
    localparam logic [3:0] S_SEND_END   = 4'd8;
    localparam logic [3:0] S_FINISH     = 4'd9;
    localparam logic [3:0] S_DONE_WAIT  = 4'd10;

    logic [3:0]                 state_reg, state_next;
    logic [SZ_W-1:0]            min_size_reg;
    logic [SZ_W-1:0]            active_reg, active_next;
    logic [MAX_CODE_BITS-1:0]   prefix_reg, prefix_next;
    logic [NF_W-1:0]            next_free_reg, next_free_next;
    logic [WD_W-1:0]            width_reg, width_next;
    logic [NF_W-1:0]            limit_reg, limit_next;
    logic                       clear_pend_reg, clear_pend_next;
    logic                       started_reg, started_next;
    logic [gle_pkg::PIX_W-1:0]  pixel_reg, pixel_next;
    logic                       last_reg, last_next;

    gle_pkg::pk_cmd_t           pk_cmd;
    gle_pkg::ht_cmd_t           ht_cmd;
    gle_pkg::ht_stat_t          ht_stat;
    logic                       pk_idle;
    logic                       send_now;
    logic [MAX_CODE_BITS-1:0]   send_code;
    logic [gle_pkg::PIX_W-1:0]  pix_masked;
    logic [MAX_CODE_BITS-1:0]   clear_code;
    logic [SZ_W-1:0]            size_clamped;
    logic                       cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == gle_pkg::REG_MIN_CODE_SIZE) ?
                       gle_pkg::APB_DW'(min_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg <= SZ_W'(gle_pkg::MIN_SIZE_RST);
        end
        else if (cfg_write && paddr[2] == gle_pkg::REG_MIN_CODE_SIZE)
        begin
            min_size_reg <= pwdata[SZ_W-1:0];
        end
    end

    // Derived values
    always_comb
    begin
        if (min_size_reg < SZ_W'(gle_pkg::MIN_SIZE_LO))
            size_clamped = SZ_W'(gle_pkg::MIN_SIZE_LO);
        else if (min_size_reg > SZ_W'(gle_pkg::MIN_SIZE_HI))
            size_clamped = SZ_W'(gle_pkg::MIN_SIZE_HI);
        else
            size_clamped = min_size_reg;
    end

    assign pix_masked = pixel_reg &
                        (gle_pkg::PIX_W'(8'hFF) >> (SZ_W'(gle_pkg::PIX_W) - active_reg));
    assign clear_code = MAX_CODE_BITS'(1) << active_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        prefix_next     = prefix_reg;
        next_free_next  = next_free_reg;
        width_next      = width_reg;
        limit_next      = limit_reg;
        clear_pend_next = clear_pend_reg;
        started_next    = started_reg;
        pixel_next      = pixel_reg;
        last_next       = last_reg;
        send_now        = 1'b0;
        send_code       = prefix_reg;
        pk_cmd          = '0;
        ht_cmd          = '0;
        ht_cmd.pixel    = pix_masked;
        ht_cmd.prefix   = gle_pkg::CODE_W_MAX'(prefix_reg);
        ht_cmd.code     = gle_pkg::CODE_W_MAX'(next_free_reg[MAX_CODE_BITS-1:0]);

        unique case (state_reg)
            S_IDLE:
            begin
                if (pix.valid)
                begin
                    pixel_next = pix.pixel;
                    last_next  = pix.last_pixel;
                    state_next = started_reg ? S_PROBE : S_START;
                end
            end
            S_START:
            begin
                active_next     = size_clamped;
                width_next      = WD_W'(size_clamped) + WD_W'(1);
                limit_next      = NF_W'(gle_pkg::limit_for(WD_W'(size_clamped) + WD_W'(1),
                                                           MAX_CODE_BITS));
                next_free_next  = (NF_W'(1) << size_clamped) + NF_W'(2);
                clear_pend_next = 1'b0;
                started_next    = 1'b1;
                ht_cmd.clear    = 1'b1;
                state_next      = S_CLR_WAIT;
            end
            S_CLR_WAIT:
            begin
                if (!ht_stat.busy)
                begin
                    state_next = S_SEND_CLR;
                end
            end
            S_SEND_CLR:
            begin
                if (pk_idle)
                begin
                    send_now    = 1'b1;
                    send_code   = clear_code;
                    prefix_next = MAX_CODE_BITS'(pix_masked);
                    state_next  = S_TAIL;
                end
            end
            S_PROBE:
            begin
                ht_cmd.start = 1'b1;
                state_next   = S_PROBE_WAIT;
            end
            S_PROBE_WAIT:
            begin
                if (!ht_stat.busy)
                begin
                    if (ht_stat.hit)
                    begin
                        prefix_next = ht_stat.code[MAX_CODE_BITS-1:0];
                        state_next  = S_TAIL;
                    end
                    else
                    begin
                        state_next = S_MISS;
                    end
                end
            end
            S_MISS:
            begin
                if (pk_idle)
                begin
                    send_now    = 1'b1;
                    prefix_next = MAX_CODE_BITS'(pix_masked);
                    if (next_free_reg < FULL_CODE)
                    begin
                        ht_cmd.insert  = ht_stat.slot;
                        next_free_next = next_free_reg + NF_W'(1);
                        state_next     = S_TAIL;
                    end
                    else
                    begin
                        // dictionary full: wipe it and send a clear code
                        next_free_next  = (NF_W'(1) << active_reg) + NF_W'(2);
                        clear_pend_next = 1'b1;
                        ht_cmd.clear    = 1'b1;
                        state_next      = S_CLR_WAIT;
                    end
                end
            end
            S_TAIL:
            begin
                if (!last_reg)
                begin
                    state_next = S_FINISH;
                end
                else if (pk_idle)
                begin
                    send_now   = 1'b1;
                    state_next = S_SEND_END;
                end
            end
            S_SEND_END:
            begin
                if (pk_idle)
                begin
                    send_now   = 1'b1;
                    send_code  = clear_code + MAX_CODE_BITS'(1);
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (pk_idle)
                begin
                    pk_cmd.end_item = 1'b1;
                    pk_cmd.last     = last_reg;
                    if (last_reg)
                    begin
                        started_next = 1'b0;
                    end
                    state_next = S_DONE_WAIT;
                end
            end
            S_DONE_WAIT:
            begin
                if (pk_idle)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Code emission and width update after each code
        if (send_now)
        begin
            pk_cmd.send  = 1'b1;
            pk_cmd.code  = gle_pkg::CODE_W_MAX'(send_code);
            pk_cmd.width = width_reg;
            if (clear_pend_reg)
            begin
                width_next      = WD_W'(active_reg) + WD_W'(1);
                limit_next      = NF_W'(gle_pkg::limit_for(WD_W'(active_reg) + WD_W'(1),
                                                           MAX_CODE_BITS));
                clear_pend_next = 1'b0;
            end
            else if (next_free_reg > limit_reg && width_reg < MAX_W)
            begin
                width_next = width_reg + WD_W'(1);
                limit_next = NF_W'(gle_pkg::limit_for(width_reg + WD_W'(1), MAX_CODE_BITS));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            active_reg     <= SZ_W'(gle_pkg::MIN_SIZE_RST);
            prefix_reg     <= '0;
            next_free_reg  <= '0;
            width_reg      <= WD_W'(9);
            limit_reg      <= NF_W'(511);
            clear_pend_reg <= 1'b0;
            started_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            prefix_reg     <= prefix_next;
            next_free_reg  <= next_free_next;
            width_reg      <= width_next;
            limit_reg      <= limit_next;
            clear_pend_reg <= clear_pend_next;
            started_reg    <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
        last_reg  <= last_next;
    end

    assign pix.ready = (state_reg == S_IDLE);

    gle_hash_table #(
        .HASH_SIZE     (HASH_SIZE),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ht_cmd),
        .stat  (ht_stat)
    );

    gle_bit_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pk_cmd),
        .idle  (pk_idle),
        .obyte (obyte)
    );

    // Checks
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pix.ready |-> (pk_idle && !ht_stat.busy))
        else $error("encoder ready while a unit is busy");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.ready) |=> !pix.ready)
        else $error("second pixel accepted while first in progress");

    a_code_fits: assert property (@(posedge clk) disable iff (!rst_n)
        pk_cmd.send |-> ((pk_cmd.code >> pk_cmd.width) == '0))
        else $error("code wider than current code width");

    a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
        (obyte.valid && obyte.stream_end) |-> obyte.run_end)
        else $error("stream end byte not marked as item end");

endmodule

// ----- bench/gif_lzw_encoder_tb.sv -----
// Self-checking testbench for the GIF LZW encoder: directed table, random images, long stalls.
`timescale 1ns / 100ps

module gif_lzw_encoder_tb;

    localparam int HS          = 5003;
    localparam int PIX_SHIFT   = 4;       // 5003 doubled four times passes 65536
    localparam int TOP_BITS    = 12;
    localparam int STALL_LIMIT = 30000;   // covers a clearing pass plus a long output stall
    localparam int DRAIN_WAIT  = 40;
    localparam logic [gle_pkg::APB_AW-1:0] ADDR_MIN_SIZE =
        gle_pkg::APB_AW'(4 * gle_pkg::REG_MIN_CODE_SIZE);

    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [7:0]  value;
        logic        last;
        bit          typed;
        int          nbytes;
        logic [31:0] bytes_lsb;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       stream_end;
    } code_byte_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [gle_pkg::APB_AW-1:0] paddr;
    logic [gle_pkg::APB_DW-1:0] pwdata;
    logic [gle_pkg::APB_DW-1:0] prdata;
    logic pready;

    gle_pix_if  pix();
    gle_byte_if obyte();

    gif_lzw_encoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix),
        .obyte   (obyte)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Scoreboard state
    code_byte_t  pending_bytes[$];
    logic [7:0]  step_bytes[$];
    int          n_err = 0;
    int          n_items = 0;
    int          n_bytes = 0;
    int          n_images = 0;
    int          n_table_clears = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;

    // Encoder mirror
    bit          dict_used[HS];
    logic [19:0] dict_key[HS];
    logic [11:0] dict_code[HS];
    int unsigned cur_prefix, free_code, cw, wlimit, acc, nbits, img_size, size_reg;
    bit          clr_pend, in_image;

    function automatic int unsigned width_cap(input int unsigned w);
        if (w >= TOP_BITS)
            return 1 << TOP_BITS;
        return (1 << w) - 1;
    endfunction

    function automatic void emit_code(input int unsigned code);
        acc   = acc & ((1 << nbits) - 1);
        acc   = acc | ((code & ((1 << cw) - 1)) << nbits);
        nbits = nbits + cw;
        while (nbits >= 8) begin
            if (step_bytes.size() < 8)
                step_bytes.push_back(acc[7:0]);
            acc   = acc >> 8;
            nbits = nbits - 8;
        end
        if (clr_pend) begin
            cw       = img_size + 1;
            wlimit   = width_cap(cw);
            clr_pend = 1'b0;
        end else if (free_code > wlimit && cw < TOP_BITS) begin
            cw     = cw + 1;
            wlimit = width_cap(cw);
        end
    endfunction

    // Lookup of (pixel, prefix); on a miss send the prefix and grow or clear the dictionary
    function automatic void encode_one(input int unsigned p);
        logic [19:0] key;
        int unsigned idx, disp, n;
        bit          hit, slot;
        key  = {p[7:0], cur_prefix[11:0]};
        idx  = (p << PIX_SHIFT) ^ cur_prefix;
        hit  = 1'b0;
        slot = 1'b0;
        if (idx >= HS) idx = idx - HS;
        if (idx >= HS) idx = 0;
        disp = (idx == 0) ? 1 : HS - idx;
        n = 0;
        while (n < HS && !hit && !slot) begin
            if (!dict_used[idx])
                slot = 1'b1;
            else if (dict_key[idx] == key)
                hit = 1'b1;
            else begin
                idx = (idx >= disp) ? idx - disp : idx + HS - disp;
                n++;
            end
        end
        if (hit) begin
            cur_prefix = dict_code[idx];
            return;
        end
        emit_code(cur_prefix);
        cur_prefix = p;
        if (free_code < (1 << TOP_BITS)) begin
            if (slot) begin
                dict_code[idx] = free_code[11:0];
                dict_key[idx]  = key;
                dict_used[idx] = 1'b1;
            end
            free_code++;
        end else begin
            foreach (dict_used[i]) dict_used[i] = 1'b0;
            free_code = (1 << img_size) + 2;
            clr_pend  = 1'b1;
            n_table_clears++;
            emit_code(1 << img_size);
        end
    endfunction

    // Bytes produced by one accepted pixel land in step_bytes
    function automatic void predict_pixel(input logic [7:0] pin, input logic last);
        int unsigned s;
        step_bytes.delete();
        if (!in_image) begin
            s = size_reg;
            if (s < gle_pkg::MIN_SIZE_LO) s = gle_pkg::MIN_SIZE_LO;
            if (s > gle_pkg::MIN_SIZE_HI) s = gle_pkg::MIN_SIZE_HI;
            img_size = s;
            foreach (dict_used[i]) dict_used[i] = 1'b0;
            cw        = s + 1;
            wlimit    = width_cap(cw);
            free_code = (1 << s) + 2;
            clr_pend  = 1'b0;
            acc       = 0;
            nbits     = 0;
            in_image  = 1'b1;
            n_images++;
            emit_code(1 << s);
            cur_prefix = pin & ((1 << img_size) - 1);
        end else begin
            encode_one(pin & ((1 << img_size) - 1));
        end
        if (last) begin
            emit_code(cur_prefix);
            emit_code((1 << img_size) + 1);
            while (nbits > 0) begin
                if (step_bytes.size() < 8)
                    step_bytes.push_back(acc[7:0]);
                acc   = acc >> 8;
                nbits = (nbits > 8) ? nbits - 8 : 0;
            end
            acc      = 0;
            in_image = 1'b0;
        end
    endfunction

    // Offer one pixel, wait for its acceptance, then queue what it should produce
    task automatic drive_pixel(input logic [7:0] p, input logic last, input bit typed,
                               input int nb, input logic [31:0] typed_bytes);
        int         gap;
        int         cnt;
        code_byte_t rec;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid      <= 1'b1;
        pix.pixel      <= p;
        pix.last_pixel <= last;
        do @(posedge clk); while (!pix.ready);
        n_items++;
        predict_pixel(p, last);
        if (typed) begin
            step_bytes.delete();
            for (int k = 0; k < nb; k++)
                step_bytes.push_back(typed_bytes[8*k +: 8]);
        end
        cnt = step_bytes.size();
        for (int k = 0; k < cnt; k++) begin
            rec.data       = step_bytes[k];
            rec.run_end    = (k == cnt - 1);
            rec.stream_end = (k == cnt - 1) && last;
            pending_bytes.push_back(rec);
        end
    endtask

    // Register write only once the block has drained
    task automatic write_min_size(input logic [3:0] v);
        pix.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MIN_SIZE;
        pwdata  <= gle_pkg::APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        size_reg = v;
    endtask

    task automatic random_image(input int len, input bit narrow);
        logic [7:0] p;
        for (int k = 0; k < len; k++) begin
            p = $urandom_range(0, 255);
            // small alphabets give repeated strings and dictionary hits
            if (narrow && $urandom_range(0, 3) != 0)
                p = $urandom_range(0, 3);
            drive_pixel(p, k == len - 1, 1'b0, 0, 32'h0);
        end
    endtask

    // Output side: random backpressure bursts, plus one long hold-off on request
    initial begin
        int gap;
        obyte.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                obyte.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 10);
                obyte.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end else begin
                gap = $urandom_range(1, 10);
                obyte.ready <= 1'b1;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Compare each output byte with the oldest expectation
    always @(posedge clk) begin
        code_byte_t want;
        if (rst_n && obyte.valid && obyte.ready) begin
            n_bytes++;
            if (pending_bytes.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("ERROR: unexpected byte %02h run_end %0b stream_end %0b",
                             obyte.out_byte, obyte.run_end, obyte.stream_end);
            end else begin
                want = pending_bytes.pop_front();
                if (want.data !== obyte.out_byte || want.run_end !== obyte.run_end ||
                    want.stream_end !== obyte.stream_end) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: byte %0d exp %02h/%0b/%0b got %02h/%0b/%0b",
                                 n_bytes, want.data, want.run_end, want.stream_end,
                                 obyte.out_byte, obyte.run_end, obyte.stream_end);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        int quiet;
        if (!rst_n || (pix.valid && pix.ready) || (obyte.valid && obyte.ready) || psel)
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("Timeout after %0d quiet cycles, %0d bytes outstanding",
                     quiet, pending_bytes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed rows; single-pixel images at size 8 are clear, pixel, end in 9 bits
    dir_row_t dir_tbl[] = '{
        '{ROW_PIX, 8'h00, 1'b1, 1'b1, 4, 32'h04040100},
        '{ROW_PIX, 8'hff, 1'b1, 1'b1, 4, 32'h0405ff00},
        '{ROW_PIX, 8'h07, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h07, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h07, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h07, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h07, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h07, 1'b1, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h00, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'hff, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h80, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h01, 1'b1, 1'b0, 0, 32'h0},
        '{ROW_CFG, 8'h02, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'hff, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h03, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h02, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h01, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h00, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h03, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h03, 1'b1, 1'b0, 0, 32'h0},
        '{ROW_CFG, 8'h00, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h05, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h06, 1'b1, 1'b0, 0, 32'h0},
        '{ROW_CFG, 8'h0f, 1'b0, 1'b0, 0, 32'h0},
        '{ROW_PIX, 8'h09, 1'b1, 1'b0, 0, 32'h0}
    };

    // Main sequence
    initial begin
        int sizes[4] = '{3, 8, 5, 2};
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pix.valid      = 1'b0;
        pix.pixel      = '0;
        pix.last_pixel = 1'b0;
        size_reg   = gle_pkg::MIN_SIZE_RST;
        img_size   = gle_pkg::MIN_SIZE_RST;
        cur_prefix = 0;
        free_code  = 0;
        cw         = 9;
        wlimit     = 511;
        acc        = 0;
        nbits      = 0;
        clr_pend   = 1'b0;
        in_image   = 1'b0;
        foreach (dict_used[i]) dict_used[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (dir_tbl[r]) begin
            if (dir_tbl[r].kind == ROW_CFG)
                write_min_size(dir_tbl[r].value[3:0]);
            else
                drive_pixel(dir_tbl[r].value, dir_tbl[r].last, dir_tbl[r].typed,
                            dir_tbl[r].nbytes, dir_tbl[r].bytes_lsb);
        end

        // random images over several code sizes
        foreach (sizes[s]) begin
            write_min_size(4'(sizes[s]));
            if (s == 1)
                hold_req = 1'b1;
            repeat (4) random_image($urandom_range(1, 12), $urandom_range(0, 1));
        end

        // no idling from here: back-to-back images at size 8
        write_min_size(4'd8);
        idle_on = 1'b0;
        random_image(20, 1'b0);
        random_image(8, 1'b1);

        pix.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d pixels in %0d images, %0d bytes checked, %0d dictionary-full clears",
                 n_items, n_images, n_bytes, n_table_clears);
        $display("Code sizes 2, 3, 5 and 8 with clamping, random stalls on both channels");
        if (n_err == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
src/gle_pkg.sv
src/gle_intf.sv
src/gle_hash_table.sv
src/gle_bit_packer.sv
src/gif_lzw_encoder.sv
bench/gif_lzw_encoder_tb.sv
